// File: rtl/scld_pkg.sv
// ----------------------------------------------------------------------------
// scld_pkg: shared types and constants for the staged coil level driver
// Holds the item and result layouts, the coil mode codes and the level table.
// ----------------------------------------------------------------------------
package scld_pkg;

  localparam int NUM_COILS       = 3;
  localparam int LEVEL_W         = 8;
  localparam int TIME_W          = 32;
  localparam int IN_TDATA_W      = 48;
  localparam int OUT_TDATA_W     = 16;
  localparam int CFG_AW          = 3;
  localparam int CFG_DW          = 32;

  localparam logic [1:0]         OP_SET    = 2'd0;
  localparam logic [1:0]         OP_UPDATE = 2'd1;
  localparam logic [1:0]         OP_OFF    = 2'd2;

  localparam logic [LEVEL_W-1:0] NO_SAVED_LEVEL  = 8'hff;
  localparam logic [LEVEL_W-1:0] LEVEL_COUNT     = 8'd7;
  localparam logic [TIME_W-1:0]  INTERVAL_RESET  = 32'd1000;

  // register index (paddr[2])
  localparam logic               REG_TOGGLE_INTERVAL = 1'b0;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_ON   = 2'd1,
    MODE_HALF = 2'd2
  } mode_t;

  typedef mode_t [NUM_COILS-1:0] coil_modes_t;

  typedef struct packed {
    logic [TIME_W-1:0]  now_time;
    logic               door_open;
    logic [LEVEL_W-1:0] level;
    logic [1:0]         op;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]   level_now;
    logic [NUM_COILS-1:0] coil_on;   // bit 0 is coil 1
    logic                 status;
  } result_t;

  typedef struct packed {
    logic [TIME_W-1:0] last_flip;
    logic              pin;
  } coil_state_t;

  // Level to coil modes; index 0 is coil 1. Only valid for levels 0..6.
  function automatic coil_modes_t level_modes(input logic [2:0] lvl);
    coil_modes_t m;
    m = '{MODE_OFF, MODE_OFF, MODE_OFF};
    case (lvl)
      3'd0: m = '{MODE_OFF,  MODE_OFF,  MODE_OFF};
      3'd1: m = '{MODE_OFF,  MODE_OFF,  MODE_HALF};
      3'd2: m = '{MODE_OFF,  MODE_OFF,  MODE_ON};
      3'd3: m = '{MODE_OFF,  MODE_HALF, MODE_ON};
      3'd4: m = '{MODE_OFF,  MODE_ON,   MODE_ON};
      3'd5: m = '{MODE_HALF, MODE_ON,   MODE_ON};
      3'd6: m = '{MODE_ON,   MODE_ON,   MODE_ON};
      default: m = '{MODE_OFF, MODE_OFF, MODE_OFF};
    endcase
    return m;
  endfunction

endpackage

// File: rtl/scld_coil.sv
// ----------------------------------------------------------------------------
// scld_coil: next pin and flip time for one coil
// Off/on coils follow their mode; half-duty coils flip once the interval has
// elapsed since the last flip (sum wraps at 2^32, zero time = not started).
// ----------------------------------------------------------------------------
module scld_coil (
  input  scld_pkg::mode_t             mode,
  input  scld_pkg::coil_state_t       cur,
  input  logic [scld_pkg::TIME_W-1:0] now_time,
  input  logic [scld_pkg::TIME_W-1:0] interval,
  input  logic                        drive,
  output scld_pkg::coil_state_t       nxt
);
  import scld_pkg::*;

  logic [TIME_W-1:0] due;

  assign due = cur.last_flip + interval;

  always_comb begin
    nxt = cur;
    if (drive) begin
      if (mode == MODE_HALF) begin
        if (cur.last_flip == '0) begin
          nxt.last_flip = now_time;
        end else if (now_time >= due) begin
          nxt.last_flip = now_time;
          nxt.pin       = ~cur.pin;
        end
      end else begin
        nxt.last_flip = '0;
        nxt.pin       = (mode == MODE_ON);
      end
    end
  end

endmodule

// File: rtl/scld_ctrl.sv
// ----------------------------------------------------------------------------
// scld_ctrl: level, door and coil state with the per-item update
// One item is decoded combinationally and applied when go is high.
// ----------------------------------------------------------------------------
module scld_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  scld_pkg::in_item_t          item,
  input  logic [scld_pkg::TIME_W-1:0] interval,
  output scld_pkg::result_t           res
);
  import scld_pkg::*;

  logic [LEVEL_W-1:0] power_level_r, power_level_nxt;
  logic [LEVEL_W-1:0] saved_level_r, saved_level_nxt;
  coil_modes_t        modes_r, modes_nxt;
  coil_state_t        coil_r   [NUM_COILS];
  coil_state_t        coil_upd [NUM_COILS];
  coil_state_t        coil_nxt [NUM_COILS];
  logic               err;
  logic               drive;
  logic               clear;

  always_comb begin
    power_level_nxt = power_level_r;
    saved_level_nxt = saved_level_r;
    modes_nxt       = modes_r;
    err             = 1'b0;
    drive           = 1'b0;
    clear           = 1'b0;
    case (item.op)
      OP_SET: begin
        power_level_nxt = item.level;
        if (item.level < LEVEL_COUNT) begin
          modes_nxt = level_modes(item.level[2:0]);
        end else begin
          err = 1'b1;
        end
      end
      OP_UPDATE: begin
        if (item.door_open) begin
          if (saved_level_r == NO_SAVED_LEVEL) begin
            saved_level_nxt = power_level_r;
          end
          if (power_level_r != '0) begin
            power_level_nxt = '0;
            modes_nxt       = level_modes(3'd0);
          end
        end else if (saved_level_r != NO_SAVED_LEVEL) begin
          power_level_nxt = saved_level_r;
          if (saved_level_r < LEVEL_COUNT) begin
            modes_nxt       = level_modes(saved_level_r[2:0]);
            saved_level_nxt = NO_SAVED_LEVEL;
          end else begin
            err = 1'b1;
          end
        end
        drive = ~err;
      end
      OP_OFF: begin
        clear = 1'b1;
      end
      default: begin
      end
    endcase
  end

  for (genvar c = 0; c < NUM_COILS; c++) begin : g_coil
    scld_coil u_coil (
      .mode     (modes_nxt[c]),
      .cur      (coil_r[c]),
      .now_time (item.now_time),
      .interval (interval),
      .drive    (drive),
      .nxt      (coil_upd[c])
    );

    always_comb begin
      coil_nxt[c] = clear ? coil_state_t'('0) : coil_upd[c];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        coil_r[c] <= '0;
      end else if (go) begin
        coil_r[c] <= coil_nxt[c];
      end
    end

    assign res.coil_on[c] = coil_nxt[c].pin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_level_r <= '0;
      saved_level_r <= NO_SAVED_LEVEL;
      modes_r       <= '{MODE_OFF, MODE_OFF, MODE_OFF};
    end else if (go) begin
      if (clear) begin
        power_level_r <= '0;
        saved_level_r <= NO_SAVED_LEVEL;
        modes_r       <= '{MODE_OFF, MODE_OFF, MODE_OFF};
      end else begin
        power_level_r <= power_level_nxt;
        saved_level_r <= saved_level_nxt;
        modes_r       <= modes_nxt;
      end
    end
  end

  assign res.status    = err;
  assign res.level_now = clear ? '0 : power_level_nxt;

endmodule

// File: rtl/staged_coil_level_driver.sv
// ----------------------------------------------------------------------------
// staged_coil_level_driver: three-coil heater drive from a power level 0..6
// Input register, combinational decode/coil update, registered result.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  in_     | in        | in_tvalid/tready   | op, level, door_open, now_time
//  out_    | out       | out_tvalid/tready  | status, coil1..3_on, level_now
//  cfg_    | in        | APB, pready = 1    | toggle_interval at 0x0
//
//  Every item passes from acceptance through the input register, where it is
//  decoded, into the result register. One item per cycle sustained while
//  out_tready stays high; state written as the result is registered, so the
//  next item sees it. A stalled result holds the result stage; the input
//  register can still take one more item, then holds it. Synchronous reset
//  clears all control and coil state and loads toggle_interval with 1000.
// ----------------------------------------------------------------------------
module staged_coil_level_driver (
  input  logic                             clk,
  input  logic                             rst_n,
  // [1:0] op, [9:2] level, [10] door_open, [42:11] now_time, rest zero
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [scld_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] status, [1] coil1_on, [2] coil2_on, [3] coil3_on, [11:4] level_now
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [scld_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [scld_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [scld_pkg::CFG_DW-1:0]      cfg_pwdata,
  output logic [scld_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                             cfg_pready
);
  import scld_pkg::*;

  localparam int ITEM_W = $bits(in_item_t);
  localparam int RES_W  = $bits(result_t);

  // config register
  logic [TIME_W-1:0] interval_r;
  logic              cfg_wr;

  // input stage
  in_item_t          item_r;
  logic              in_valid_r, in_valid_nxt;
  logic              in_fire;

  // result stage
  result_t           res, res_r;
  logic              out_valid_r, out_valid_nxt;
  logic              advance;

  // ---------------- APB ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= INTERVAL_RESET;
    end else if (cfg_wr && cfg_paddr[2] == REG_TOGGLE_INTERVAL) begin
      interval_r <= cfg_pwdata;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_TOGGLE_INTERVAL) ? interval_r : '0;

  // ---------------- pipeline control ----------------
  // the item in the input register moves on when the result slot is free
  assign advance   = in_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~in_valid_r | advance;
  assign in_fire   = in_tvalid & in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_fire) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_item_t'(in_tdata[ITEM_W-1:0]);
    end
    if (advance) begin
      res_r <= res;
    end
  end

  // ---------------- decode and coil update ----------------
  scld_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (advance),
    .item     (item_r),
    .interval (interval_r),
    .res      (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-RES_W){1'b0}}, res_r};

  // ---------------- assertions ----------------
  // a turn-off item always reports a cleared state
  a_off_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && item_r.op == OP_OFF |=> out_tdata[RES_W-1:0] == '0)
    else $error("turn-off item did not clear the result");

  // an error is only reported with an out-of-range stored level
  a_err_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[11:4] >= LEVEL_COUNT)
    else $error("error status with a valid level");

  // a full pipeline with a stalled output refuses new items
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && out_valid_r && !out_tready |-> !in_tready)
    else $error("input accepted while pipeline full and stalled");

  // the result register only loads when an item moves on
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r && !out_valid_r |=> !out_tvalid)
    else $error("result appeared without an item");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the staged coil level driver
// Streams set-level, update and turn-off items through the block under
// several toggle intervals and idle patterns, predicts every result and
// checks it field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import scld_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int ITEMS_PER_RUN = 175;
  localparam int NUM_RUNS      = 8;
  localparam int IN_PAD_W      = IN_TDATA_W - $bits(in_item_t);
  localparam logic [CFG_AW-1:0] ADDR_TOGGLE_INTERVAL = {REG_TOGGLE_INTERVAL, 2'b00};

  // ---------------------------------------------------------------------------
  // DUT signals; the inputs are known from time zero
  // ---------------------------------------------------------------------------
  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [1:0] op, [9:2] level, [10] door_open,
                                           // [42:11] now_time, rest zero
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [0] status, [1] coil1_on, [2] coil2_on,
                                           // [3] coil3_on, [11:4] level_now
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]      cfg_paddr = '0;
  logic [CFG_DW-1:0]      cfg_pwdata = '0;
  logic [CFG_DW-1:0]      cfg_prdata;
  logic                   cfg_pready;

  staged_coil_level_driver u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow state of the heater controller
  // ---------------------------------------------------------------------------
  logic [TIME_W-1:0]  interval_q;
  logic [LEVEL_W-1:0] heat_level;
  logic [LEVEL_W-1:0] parked_level;   // level held while the door is open
  mode_t              coil_mode_q [NUM_COILS];
  logic [TIME_W-1:0]  flip_stamp [NUM_COILS];
  logic               pin_q [NUM_COILS];

  in_item_t coil_cmd_q [$];           // items waiting for the driver
  result_t  coil_result_q [$];        // predicted results, oldest first
  in_item_t drv_item;
  result_t  mon_got;
  result_t  mon_want;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int n_items       = 0;
  int n_results     = 0;
  int n_errors      = 0;
  int n_flips       = 0;
  int n_level_errs  = 0;
  int n_settings    = 0;
  int cycle_cnt     = 0;

  function automatic void set_modes(input mode_t m1, input mode_t m2, input mode_t m3);
    coil_mode_q[0] = m1;
    coil_mode_q[1] = m2;
    coil_mode_q[2] = m3;
  endfunction

  // Stores the level; only 0..6 reload the coil modes. Returns 1 on a bad level.
  function automatic bit store_level(input logic [LEVEL_W-1:0] lvl);
    heat_level = lvl;
    if (lvl >= LEVEL_COUNT) return 1'b1;
    case (lvl[2:0])
      3'd0:    set_modes(MODE_OFF,  MODE_OFF,  MODE_OFF);
      3'd1:    set_modes(MODE_HALF, MODE_OFF,  MODE_OFF);
      3'd2:    set_modes(MODE_ON,   MODE_OFF,  MODE_OFF);
      3'd3:    set_modes(MODE_ON,   MODE_HALF, MODE_OFF);
      3'd4:    set_modes(MODE_ON,   MODE_ON,   MODE_OFF);
      3'd5:    set_modes(MODE_ON,   MODE_ON,   MODE_HALF);
      default: set_modes(MODE_ON,   MODE_ON,   MODE_ON);
    endcase
    return 1'b0;
  endfunction

  function automatic void clear_heater();
    heat_level   = '0;
    parked_level = NO_SAVED_LEVEL;
    for (int c = 0; c < NUM_COILS; c++) begin
      coil_mode_q[c] = MODE_OFF;
      flip_stamp[c]  = '0;
      pin_q[c]       = 1'b0;
    end
  endfunction

  // Advances the shadow state by one item and returns the result it should give.
  function automatic result_t coil_predict(input in_item_t it);
    result_t           r;
    bit                err;
    logic [TIME_W-1:0] due;
    err = 1'b0;
    case (it.op)
      OP_SET: err = store_level(it.level);
      OP_UPDATE: begin
        if (it.door_open) begin
          // park the level once, then force everything off
          if (parked_level == NO_SAVED_LEVEL) parked_level = heat_level;
          if (heat_level != '0) err = store_level('0);
        end else if (parked_level != NO_SAVED_LEVEL) begin
          err = store_level(parked_level);
          if (!err) parked_level = NO_SAVED_LEVEL;
        end
        // a bad restored level freezes pins and stamps for this item
        if (!err) begin
          for (int c = 0; c < NUM_COILS; c++) begin
            if (coil_mode_q[c] == MODE_HALF) begin
              due = flip_stamp[c] + interval_q;   // wraps at 2^32
              if (flip_stamp[c] == '0) begin
                flip_stamp[c] = it.now_time;      // first sight starts the coil
              end else if (it.now_time >= due) begin
                flip_stamp[c] = it.now_time;
                pin_q[c]      = ~pin_q[c];
                n_flips++;
              end
            end else begin
              flip_stamp[c] = '0;
              pin_q[c]      = (coil_mode_q[c] == MODE_ON);
            end
          end
        end
      end
      OP_OFF: clear_heater();
      default: ;
    endcase
    if (err) n_level_errs++;
    r.status    = err;
    r.coil_on   = {pin_q[2], pin_q[1], pin_q[0]};
    r.level_now = heat_level;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued items, random gaps between them
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        coil_result_q.push_back(coil_predict(drv_item));
        n_items++;
      end
      if (!in_tvalid || in_tready) begin
        if (coil_cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_item  = coil_cmd_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {{IN_PAD_W{1'b0}}, drv_item};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      mon_got = result_t'(out_tdata[$bits(result_t)-1:0]);
      if (coil_result_q.size() == 0) begin
        $error("result %h arrived with no item outstanding", out_tdata);
        n_errors++;
      end else begin
        mon_want = coil_result_q.pop_front();
        n_results++;
        check_field("status",    8'(mon_want.status),     8'(mon_got.status));
        check_field("coil1_on",  8'(mon_want.coil_on[0]), 8'(mon_got.coil_on[0]));
        check_field("coil2_on",  8'(mon_want.coil_on[1]), 8'(mon_got.coil_on[1]));
        check_field("coil3_on",  8'(mon_want.coil_on[2]), 8'(mon_got.coil_on[2]));
        check_field("level_now", mon_want.level_now,      mon_got.level_now);
      end
    end
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("staged_coil_level_driver test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Register access; pready is expected high but still honored
  // ---------------------------------------------------------------------------
  task automatic write_interval(input logic [TIME_W-1:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_TOGGLE_INTERVAL;
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    interval_q = val;
    n_settings++;
  endtask

  // read back during the access phase, sampled away from the clock edge
  task automatic read_interval_check();
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= ADDR_TOGGLE_INTERVAL;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    while (!cfg_pready) @(negedge clk);
    if (cfg_prdata !== interval_q) begin
      $error("toggle_interval: expected %0d, got %0d", interval_q, cfg_prdata);
      n_errors++;
    end
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_cmd(input logic [1:0] op, input logic [LEVEL_W-1:0] lvl,
                          input logic door, input logic [TIME_W-1:0] now);
    in_item_t it;
    it.op        = op;
    it.level     = lvl;
    it.door_open = door;
    it.now_time  = now;
    coil_cmd_q.push_back(it);
  endtask

  // Block is idle once nothing is queued, on the bus or outstanding.
  task automatic wait_drained();
    @(negedge clk);
    while (coil_cmd_q.size() != 0 || in_tvalid || coil_result_q.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Mostly update items on a running clock, so half-duty coils really toggle;
  // level changes, door open/close spells, jumps in time and turn-offs mixed in.
  task automatic queue_random(input int count);
    logic [TIME_W-1:0] tick;
    logic              door;
    int                pick;
    case ($urandom_range(3))
      0, 1:    tick = $urandom;
      2:       tick = 32'hffff_f000 + $urandom_range(0, 4095);   // run across the wrap
      default: tick = $urandom_range(0, 100);
    endcase
    door = 1'b0;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        if ($urandom_range(99) < 85)
          push_cmd(OP_SET, LEVEL_W'($urandom_range(0, 6)), 1'($urandom), $urandom);
        else
          push_cmd(OP_SET, LEVEL_W'($urandom_range(0, 255)), 1'($urandom), $urandom);
      end else if (pick < 98) begin
        if ($urandom_range(99) < 12) door = ~door;
        pick = $urandom_range(99);
        if (pick < 3) begin
          push_cmd(OP_UPDATE, LEVEL_W'($urandom), door, '0);   // coil not started
        end else if (pick < 6) begin
          tick = $urandom;
          push_cmd(OP_UPDATE, LEVEL_W'($urandom), door, tick);
        end else begin
          if (interval_q <= 32'd4096)
            tick = tick + $urandom_range(0, 2 * interval_q);
          else if ($urandom_range(9) == 0)
            tick = tick + $urandom;
          else
            tick = tick + $urandom_range(0, 4096);
          push_cmd(OP_UPDATE, LEVEL_W'($urandom), door, tick);
        end
      end else begin
        push_cmd(OP_OFF, LEVEL_W'($urandom), 1'($urandom), $urandom);
        door = 1'b0;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [TIME_W-1:0] ival;

    interval_q = INTERVAL_RESET;
    clear_heater();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    read_interval_check();   // reset value

    // directed: every op, level extremes, door park/restore, wrap of the due time
    @(negedge clk);
    push_cmd(OP_UPDATE, 8'd0,   1'b0, 32'd0);
    push_cmd(OP_SET,    8'd255, 1'b0, 32'd0);          // bad level: stored, modes kept
    push_cmd(OP_UPDATE, 8'd0,   1'b0, 32'd10);
    push_cmd(OP_SET,    8'd1,   1'b0, 32'd0);
    push_cmd(OP_UPDATE, 8'd0,   1'b0, 32'd0);          // time 0 leaves the coil unstarted
    push_cmd(OP_UPDATE, 8'd0,   1'b0, 32'd100);        // starts coil 1
    push_cmd(OP_UPDATE, 8'd0,   1'b0, 32'd1099);       // one tick short
    push_cmd(OP_UPDATE, 8'd0,   1'b0, 32'd1100);       // flips
    push_cmd(OP_SET,    8'd3,   1'b0, 32'd0);
    push_cmd(OP_UPDATE, 8'd0,   1'b0, 32'd2100);
    push_cmd(OP_SET,    8'd5,   1'b0, 32'd0);
    push_cmd(OP_UPDATE, 8'd0,   1'b0, 32'd3200);
    push_cmd(OP_UPDATE, 8'd0,   1'b0, 32'd4200);
    push_cmd(OP_SET,    8'd6,   1'b0, 32'd0);
    push_cmd(OP_SET,    8'd4,   1'b0, 32'd0);
    push_cmd(OP_SET,    8'd2,   1'b0, 32'd0);
    push_cmd(OP_SET,    8'd5,   1'b0, 32'd0);
    push_cmd(OP_UPDATE, 8'd0,   1'b1, 32'd6000);       // door opens: park 5, force 0
    push_cmd(OP_UPDATE, 8'd0,   1'b1, 32'd7000);       // still open, parked level kept
    push_cmd(OP_UPDATE, 8'd0,   1'b0, 32'd8000);       // door closes: restore 5
    push_cmd(OP_SET,    8'd7,   1'b0, 32'd0);          // smallest bad level
    push_cmd(OP_UPDATE, 8'd0,   1'b1, 32'd9000);
    push_cmd(OP_UPDATE, 8'd0,   1'b0, 32'd10000);      // bad level restored: error, frozen
    push_cmd(OP_UPDATE, 8'd0,   1'b0, 32'd11000);
    push_cmd(OP_OFF,    8'd0,   1'b0, 32'd0);
    push_cmd(OP_SET,    8'd1,   1'b0, 32'd0);
    push_cmd(OP_UPDATE, 8'd0,   1'b0, 32'hffff_ff00);
    push_cmd(OP_UPDATE, 8'd0,   1'b0, 32'hffff_ffff);  // due time wrapped past zero
    push_cmd(OP_OFF,    8'hff,  1'b1, 32'hffff_ffff);
    wait_drained();

    // random runs: each with its own interval and idle pattern
    for (int run = 0; run < NUM_RUNS; run++) begin
      case (run)
        0:       ival = 32'd1;
        1:       ival = 32'hffff_ffff;
        2:       ival = INTERVAL_RESET;
        3:       ival = $urandom_range(2, 64);
        4: begin
          ival = $urandom;
          if (ival == '0) ival = 32'd1;
        end
        5:       ival = $urandom_range(1, 16);
        6:       ival = 32'h8000_0000;
        default: ival = $urandom_range(100, 3000);
      endcase
      write_interval(ival);
      read_interval_check();
      case (run % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 85; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 85; end
        default: begin send_idle_pct = 13; stall_pct = 13; end
      endcase
      @(negedge clk);
      queue_random(ITEMS_PER_RUN);
      wait_drained();
    end

    repeat (8) @(negedge clk);
    $display("Covered %0d items / %0d results over %0d interval settings and four idle patterns",
             n_items, n_results, n_settings);
    $display("Predicted %0d coil pin flips and %0d bad-level results", n_flips, n_level_errs);
    if (n_errors == 0) begin
      $display("staged_coil_level_driver test passed");
    end else begin
      $display("staged_coil_level_driver test failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/scld_pkg.sv
rtl/scld_coil.sv
rtl/scld_ctrl.sv
rtl/staged_coil_level_driver.sv
test/tb_top.sv
